// File: hw/rtl/hdbl_pkg.sv
// Shared event codes, link phases and ring control for the half-duplex byte link.
package hdbl_pkg;

    typedef enum logic [2:0] {
        K_WRITE    = 3'd0,
        K_READ     = 3'd1,
        K_RX_BYTE  = 3'd2,
        K_RX_ERROR = 3'd3,
        K_TX_READY = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PENDING = 2'd1,
        PH_AWAIT   = 2'd2
    } t_phase;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_ring_ctl;

endpackage

// File: hw/rtl/hdbl_ring.sv
// Receive ring storage: one write port, one registered read port, write-first bypass.
module hdbl_ring #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                  i_clk,
    input  hdbl_pkg::t_ring_ctl   i_ctl,
    input  logic [AW-1:0]         i_waddr,
    input  logic [7:0]            i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output logic [7:0]            o_rdata
);
    import hdbl_pkg::*;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // a read issued on the same edge as a write to that entry sees the new byte
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            if (i_ctl.wr_en && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/half_duplex_byte_link_with_rx_ring.sv
// Half-duplex byte link: send/echo check, transmitter enables and receive ring.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | sink      | i_in_valid / o_in_stall | i_kind, i_data
//  out     | source    | o_out_valid / i_out_stall | o_read_data .. o_link_state
//
// An item is taken, the ring is read at the read pointer on that edge, and the
// result is then committed into the output register: one item per cycle
// sustained while the output is not stalled, as the registered read of the ring
// memory overlaps with the commit of the item before. Reset is synchronous and
// needs no clearing pass: the fill count guards unwritten ring entries. While
// the output register holds an untaken beat, a finished item waits in the
// execute stage and the input stalls.
module half_duplex_byte_link_with_rx_ring #(
    parameter int RING_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_kind,
    input  logic [7:0] i_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_read_data,
    output logic       o_read_empty,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_data,
    output logic       o_collision,
    output logic       o_dropped,
    output logic       o_transmit_enabled,
    output logic       o_tx_irq_enabled,
    output logic [1:0] o_link_state
);
    import hdbl_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(RING_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(RING_DEPTH);

    // execute stage
    logic          r_busy;
    logic [2:0]    r_kind;
    logic [7:0]    r_data;

    // link state
    t_phase        r_phase, n_phase;
    logic [7:0]    r_pending, n_pending;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [CW-1:0] r_fill, n_fill;
    logic          r_tx_en, n_tx_en;
    logic          r_irq_en, n_irq_en;

    // output beat
    logic          r_out_valid;
    logic [7:0]    r_read_data, n_read_data;
    logic          r_read_empty, n_read_empty;
    logic          r_tx_valid, n_tx_valid;
    logic [7:0]    r_tx_data, n_tx_data;
    logic          r_collision, n_collision;
    logic          r_dropped, n_dropped;

    logic          commit;
    logic          accept;
    logic          store;
    logic [7:0]    ring_q;
    t_ring_ctl     ring_ctl;
    logic [AW-1:0] rd_addr;

    assign commit     = r_busy && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_busy && !commit;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_phase      = r_phase;
        n_pending    = r_pending;
        n_rd_ptr     = r_rd_ptr;
        n_wr_ptr     = r_wr_ptr;
        n_fill       = r_fill;
        n_tx_en      = r_tx_en;
        n_irq_en     = r_irq_en;
        n_read_data  = 8'd0;
        n_read_empty = 1'b0;
        n_tx_valid   = 1'b0;
        n_tx_data    = 8'd0;
        n_collision  = 1'b0;
        n_dropped    = 1'b0;
        store        = 1'b0;
        case (r_kind)
            K_WRITE: begin
                n_pending = r_data;
                n_phase   = PH_PENDING;
                n_tx_en   = 1'b1;
                n_irq_en  = 1'b1;
            end
            K_READ: begin
                if (r_fill != '0) begin
                    n_read_data = ring_q;
                    n_rd_ptr    = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
                    n_fill      = r_fill - CW'(1);
                end else begin
                    n_read_empty = 1'b1;
                end
            end
            K_RX_BYTE: begin
                if (r_phase == PH_IDLE) begin
                    if (r_fill >= FULL_CNT) begin
                        n_dropped = 1'b1;
                    end else begin
                        store    = 1'b1;
                        n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
                        n_fill   = r_fill + CW'(1);
                    end
                end else begin
                    // echo of our own byte: any difference means another sender
                    if (r_data != r_pending) begin
                        n_collision = 1'b1;
                        n_tx_en     = 1'b0;
                        n_irq_en    = 1'b0;
                    end
                    n_phase = PH_IDLE;
                end
            end
            K_RX_ERROR: begin
                n_tx_en  = 1'b0;
                n_irq_en = 1'b0;
            end
            K_TX_READY: begin
                if (r_phase == PH_PENDING) begin
                    n_tx_valid = 1'b1;
                    n_tx_data  = r_pending;
                    n_phase    = PH_AWAIT;
                end else begin
                    n_irq_en = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // next item reads at the pointer left by the item committing now
    assign rd_addr        = commit ? n_rd_ptr : r_rd_ptr;
    assign ring_ctl.wr_en = commit && store;
    assign ring_ctl.rd_en = accept;

    hdbl_ring #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_ctl   (ring_ctl),
        .i_waddr (r_wr_ptr),
        .i_wdata (r_data),
        .i_raddr (rd_addr),
        .o_rdata (ring_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_pending   <= 8'd0;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_fill      <= '0;
            r_tx_en     <= 1'b0;
            r_irq_en    <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (commit) begin
                r_busy <= 1'b0;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_pending   <= n_pending;
                r_rd_ptr    <= n_rd_ptr;
                r_wr_ptr    <= n_wr_ptr;
                r_fill      <= n_fill;
                r_tx_en     <= n_tx_en;
                r_irq_en    <= n_irq_en;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_data <= i_data;
        end
        if (commit) begin
            r_read_data  <= n_read_data;
            r_read_empty <= n_read_empty;
            r_tx_valid   <= n_tx_valid;
            r_tx_data    <= n_tx_data;
            r_collision  <= n_collision;
            r_dropped    <= n_dropped;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_read_data        = r_read_data;
    assign o_read_empty       = r_read_empty;
    assign o_tx_valid         = r_tx_valid;
    assign o_tx_data          = r_tx_data;
    assign o_collision        = r_collision;
    assign o_dropped          = r_dropped;
    assign o_transmit_enabled = r_tx_en;
    assign o_tx_irq_enabled   = r_irq_en;
    assign o_link_state       = r_phase;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_CNT)
        else $error("ring fill count above depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) |-> (r_rd_ptr == r_wr_ptr))
        else $error("empty ring with unequal pointers");

    a_tx_await: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_tx_valid) |-> (r_phase == PH_AWAIT))
        else $error("byte sent but link not awaiting echo");

    a_coll_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_collision) |-> (!r_tx_en && !r_irq_en && r_phase == PH_IDLE))
        else $error("collision left transmitter enabled");

    a_hold_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && !commit || !r_busy || $stable(r_phase)))
        else $error("state moved while result beat stalled");

endmodule
